// File: hw/rtl/srsc_pkg.sv
package srsc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_INIT  = 3'd1,
        MODE_RUN   = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_HALT  = 3'd4,
        MODE_ERROR = 3'd5,
        MODE_RESET = 3'd6
    } mode_t;

    localparam logic [0:0] CFG_DEBOUNCE_LIMIT = 1'b0;
    localparam logic [0:0] CFG_RESET_TIMEOUT  = 1'b1;

    localparam int unsigned CFG_DATA_BITS = 16;

    localparam logic [3:0]  STALE_LIMIT  = 4'd10;
    localparam logic [3:0]  STALE_MAX    = 4'd15;
    localparam logic [7:0]  DEBOUNCE_MAX = 8'hFF;
    localparam logic [15:0] TIMER_MAX    = 16'hFFFF;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  debounce_count;
        logic [3:0]  stale_count;
        logic [15:0] error_timer;
    } state_t;

    typedef struct packed {
        logic       estop_pressed;
        logic       error_flag;
        logic       halt_flag;
        logic       halt_ok;
    } flags_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       enable_strobe;
        logic       disable_strobe;
        logic       drive_update;
        logic       halt_control;
        logic       clear_errors;
        logic       estop_assert;
        logic       estop_release;
    } result_t;

endpackage

// File: hw/rtl/safety_run_state_controller.sv
// Channel   Direction  Handshake              Payload
// tick      in         s_valid / s_ready      s_commanded_state, s_estop_pressed, s_error_flag,
//                                             s_halt_flag, s_halt_ok, s_heartbeat
// result    out        m_valid / m_ready      m_mode and the seven strobes
// config    in         cfg_we                 cfg_index, cfg_data
//
// A tick is captured in an input register, evaluated combinationally against the mode and
// counters and written to the result register, which drives the result port; the state
// registers are updated on the same edge as the result register.
// One tick per cycle is sustained while the result port is not stalled.
// Reset is synchronous on aresetn low and restores idle mode, zero counters and the
// register defaults. A stalled result holds the result register and, behind it, the
// input register; s_ready drops only when both are full.
module safety_run_state_controller #(
    parameter int unsigned HEARTBEAT_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [15:0]               cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_commanded_state,
    input  logic                      s_estop_pressed,
    input  logic                      s_error_flag,
    input  logic                      s_halt_flag,
    input  logic                      s_halt_ok,
    input  logic [HEARTBEAT_BITS-1:0] s_heartbeat,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_mode,
    output logic                      m_enable_strobe,
    output logic                      m_disable_strobe,
    output logic                      m_drive_update,
    output logic                      m_halt_control,
    output logic                      m_clear_errors,
    output logic                      m_estop_assert,
    output logic                      m_estop_release
);

    logic [7:0]                debounce_limit_reg;
    logic [15:0]               reset_timeout_reg;

    srsc_pkg::state_t          state_reg;
    srsc_pkg::state_t          state_next;
    logic [HEARTBEAT_BITS-1:0] last_hb_reg;
    logic [HEARTBEAT_BITS-1:0] last_hb_next;

    logic                      in_valid_reg;
    logic [2:0]                cmd_reg;
    srsc_pkg::flags_t          flags_reg;
    logic [HEARTBEAT_BITS-1:0] hb_reg;

    logic                      out_valid_reg;
    srsc_pkg::result_t         result_reg;
    srsc_pkg::result_t         result_next;

    logic                      advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_limit_reg <= 8'd5;
            reset_timeout_reg  <= 16'd1000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                srsc_pkg::CFG_DEBOUNCE_LIMIT: debounce_limit_reg <= cfg_data[7:0];
                srsc_pkg::CFG_RESET_TIMEOUT:  reset_timeout_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_commanded_state;
            flags_reg <= '{estop_pressed: s_estop_pressed, error_flag: s_error_flag,
                           halt_flag: s_halt_flag, halt_ok: s_halt_ok};
            hb_reg    <= s_heartbeat;
        end
    end

    srsc_step #(
        .HEARTBEAT_BITS(HEARTBEAT_BITS)
    ) u_step (
        .state_cur      (state_reg),
        .last_hb        (last_hb_reg),
        .debounce_limit (debounce_limit_reg),
        .reset_timeout  (reset_timeout_reg),
        .cmd            (cmd_reg),
        .flags          (flags_reg),
        .hb             (hb_reg),
        .state_next     (state_next),
        .last_hb_next   (last_hb_next),
        .result         (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '{mode: srsc_pkg::MODE_IDLE, debounce_count: 8'd0,
                             stale_count: 4'd0, error_timer: 16'd0};
            last_hb_reg <= '0;
        end else if (advance) begin
            state_reg   <= state_next;
            last_hb_reg <= last_hb_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_mode           = result_reg.mode;
    assign m_enable_strobe  = result_reg.enable_strobe;
    assign m_disable_strobe = result_reg.disable_strobe;
    assign m_drive_update   = result_reg.drive_update;
    assign m_halt_control   = result_reg.halt_control;
    assign m_clear_errors   = result_reg.clear_errors;
    assign m_estop_assert   = result_reg.estop_assert;
    assign m_estop_release  = result_reg.estop_release;

endmodule

// File: hw/rtl/srsc_step.sv
module srsc_step #(
    parameter int unsigned HEARTBEAT_BITS = 16
) (
    input  srsc_pkg::state_t         state_cur,
    input  logic [HEARTBEAT_BITS-1:0] last_hb,
    input  logic [7:0]               debounce_limit,
    input  logic [15:0]              reset_timeout,
    input  logic [2:0]               cmd,
    input  srsc_pkg::flags_t         flags,
    input  logic [HEARTBEAT_BITS-1:0] hb,
    output srsc_pkg::state_t         state_next,
    output logic [HEARTBEAT_BITS-1:0] last_hb_next,
    output srsc_pkg::result_t        result
);

    // The branches are evaluated in the order idle, init, run, stop, halt, reset, error so that
    // a state left early in a tick hands over to the logic of the state it moves to.
    always_comb begin
        srsc_pkg::mode_t m;
        logic            done;
        logic [7:0]      deb;
        logic [3:0]      stale;
        logic [15:0]     timer;

        m     = state_cur.mode;
        done  = 1'b0;
        deb   = state_cur.debounce_count;
        stale = state_cur.stale_count;
        timer = state_cur.error_timer;
        last_hb_next = last_hb;
        result = '0;

        if (flags.estop_pressed) begin
            if (deb != srsc_pkg::DEBOUNCE_MAX) begin
                deb = deb + 8'd1;
            end
        end else if (deb != 8'd0) begin
            deb = deb - 8'd1;
        end

        if (m == srsc_pkg::MODE_IDLE) begin
            result.estop_release = 1'b1;
            if (cmd == srsc_pkg::MODE_RUN) begin
                m = srsc_pkg::MODE_INIT;
            end
            done = 1'b1;
        end

        if (!done && m == srsc_pkg::MODE_INIT) begin
            result.clear_errors = 1'b1;
            stale = 4'd0;
            if (flags.estop_pressed || flags.error_flag || flags.halt_flag) begin
                m = srsc_pkg::MODE_ERROR;
                timer = 16'd0;
            end else begin
                result.enable_strobe = 1'b1;
                m = srsc_pkg::MODE_RUN;
                done = 1'b1;
            end
        end

        if (!done && m == srsc_pkg::MODE_RUN) begin
            if (cmd == srsc_pkg::MODE_STOP || cmd == srsc_pkg::MODE_IDLE) begin
                m = srsc_pkg::MODE_STOP;
            end else if (cmd == srsc_pkg::MODE_HALT) begin
                m = srsc_pkg::MODE_HALT;
            end else if (cmd == srsc_pkg::MODE_ERROR) begin
                m = srsc_pkg::MODE_ERROR;
                timer = 16'd0;
            end
            if (hb == last_hb) begin
                if (stale != srsc_pkg::STALE_MAX) begin
                    stale = stale + 4'd1;
                end
            end else begin
                stale = 4'd0;
            end
            last_hb_next = hb;
            if (stale >= srsc_pkg::STALE_LIMIT) begin
                m = srsc_pkg::MODE_ERROR;
            end
            if (flags.halt_flag) begin
                m = srsc_pkg::MODE_HALT;
            end
            if (deb > debounce_limit) begin
                m = srsc_pkg::MODE_ERROR;
                timer = 16'd0;
            end
            if (flags.error_flag) begin
                m = srsc_pkg::MODE_ERROR;
                timer = 16'd0;
                result.disable_strobe = 1'b1;
            end
            if (m == srsc_pkg::MODE_RUN) begin
                result.drive_update = 1'b1;
                done = 1'b1;
            end
        end

        if (!done && m == srsc_pkg::MODE_STOP) begin
            result.disable_strobe = 1'b1;
            m = srsc_pkg::MODE_IDLE;
            done = 1'b1;
        end

        if (!done && m == srsc_pkg::MODE_HALT) begin
            if (deb > debounce_limit) begin
                m = srsc_pkg::MODE_ERROR;
                timer = 16'd0;
            end
            if (flags.error_flag) begin
                m = srsc_pkg::MODE_ERROR;
                result.disable_strobe = 1'b1;
                timer = 16'd0;
            end
            if (m == srsc_pkg::MODE_HALT) begin
                result.halt_control = 1'b1;
                if (!flags.halt_ok) begin
                    m = srsc_pkg::MODE_ERROR;
                    result.disable_strobe = 1'b1;
                    timer = 16'd0;
                end
                done = 1'b1;
            end
        end

        if (!done && m == srsc_pkg::MODE_RESET) begin
            result.estop_release = 1'b1;
            result.clear_errors = 1'b1;
            stale = 4'd0;
            deb = 8'd0;
            m = srsc_pkg::MODE_IDLE;
            done = 1'b1;
        end

        if (!done && m == srsc_pkg::MODE_ERROR) begin
            result.estop_assert = 1'b1;
            if (timer != srsc_pkg::TIMER_MAX) begin
                timer = timer + 16'd1;
            end
            if (cmd == srsc_pkg::MODE_RESET && timer > reset_timeout) begin
                m = srsc_pkg::MODE_RESET;
            end
        end

        result.mode = m;
        state_next.mode = m;
        state_next.debounce_count = deb;
        state_next.stale_count = stale;
        state_next.error_timer = timer;
    end

endmodule

// File: hw/rtl/srsc_checker.sv
module srsc_assertions (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_mode,
    input logic       m_enable_strobe,
    input logic       m_drive_update,
    input logic       m_clear_errors,
    input logic       m_estop_release
);

    // Arming the outputs and updating the drive are only reported with the block in run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_enable_strobe || m_drive_update) |-> m_mode == srsc_pkg::MODE_RUN)
        else $error("enable or drive strobe outside run mode");

    // Releasing the e-stop line happens in idle, which may step to init, or on reset to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_estop_release |->
            m_mode == srsc_pkg::MODE_IDLE || m_mode == srsc_pkg::MODE_INIT)
        else $error("e-stop release with an unexpected mode");

    // Clearing errors comes from init or reset, which end in run, error, reset or idle;
    // an init that fails drops into error, which may already honor a reset command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clear_errors |->
            m_mode == srsc_pkg::MODE_RUN || m_mode == srsc_pkg::MODE_ERROR ||
            m_mode == srsc_pkg::MODE_RESET || m_mode == srsc_pkg::MODE_IDLE)
        else $error("error clear with an unexpected mode");

    // A result that is not taken stays on the port unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mode))
        else $error("result changed while stalled");

endmodule

bind safety_run_state_controller srsc_assertions u_srsc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_mode          (m_mode),
    .m_enable_strobe (m_enable_strobe),
    .m_drive_update  (m_drive_update),
    .m_clear_errors  (m_clear_errors),
    .m_estop_release (m_estop_release)
);
